// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define QF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define QF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/qf_pkg.sv =====
// ----------------------------------------------------------------------------
// qf_pkg
// Shared types and fixed constants of the quaternion fractal iteration core.
// ----------------------------------------------------------------------------
`default_nettype none

package qf_pkg;

  localparam int DERIV_W    = 32;
  localparam int NORM_W     = 30;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SQ_SUM_W   = SQ_W + 2;
  localparam int ROOT_W     = SQ_SUM_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int RATIO_FRAC = 20;
  localparam int NUM_SH     = RATIO_FRAC - 1;
  localparam int QUOT_W     = 26;  // ratio stays below 64, so 26 bits hold it
  localparam int SCALE_SH   = 12;
  localparam int ROT_SH     = 14;
  localparam int BLEND_SH   = 12;
  localparam int OFF_FRAC   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE,
    CFG_OFFSET,
    CFG_ROW_ONE,
    CFG_ROW_TWO,
    CFG_ROW_THREE,
    CFG_BLEND,
    CFG_ROTATE
  } qf_cfg_idx_t;

  typedef struct packed {
    logic [63:0]      scale;
    logic [63:0]      offset;
    logic [2:0][47:0] row;
    logic [15:0]      blend;
    logic             rotate;
  } qf_cfg_t;

  localparam logic [63:0] SCALE_RST  = 64'h1000_1000_1000_1000;
  localparam logic [47:0] ROW0_RST   = 48'h0000_0000_4000;
  localparam logic [47:0] ROW1_RST   = 48'h0000_4000_0000;
  localparam logic [47:0] ROW2_RST   = 48'h4000_0000_0000;
  localparam logic [15:0] BLEND_RST  = 16'h1000;

endpackage

`default_nettype wire

// ===== rtl/core/qf_isqrt.sv =====
// ----------------------------------------------------------------------------
// qf_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qf_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qf_pkg::SQ_SUM_W-1:0]   rad_in,
  output logic [qf_pkg::ROOT_W-1:0]     root
);

  localparam int N  = qf_pkg::ROOT_STEPS;
  localparam int VW = qf_pkg::SQ_SUM_W;

  logic [VW-1:0] rem_r [1:N];
  logic [VW-1:0] res_r [1:N];
  logic [VW-1:0] rem_s [0:N-1];
  logic [VW-1:0] res_s [0:N-1];

  assign rem_s[0] = rad_in;
  assign res_s[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [VW-1:0] bitv;
    logic [VW-1:0] trial;
    logic [VW-1:0] rem_nxt;
    logic [VW-1:0] res_nxt;

    if (k > 0) begin : g_link
      assign rem_s[k] = rem_r[k];
      assign res_s[k] = res_r[k];
    end

    always_comb begin
      bitv  = VW'(1) << (2 * (N - 1 - k));
      trial = res_s[k] + bitv;
      if (rem_s[k] >= trial) begin
        rem_nxt = rem_s[k] - trial;
        res_nxt = (res_s[k] >> 1) + bitv;
      end else begin
        rem_nxt = rem_s[k];
        res_nxt = res_s[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        res_r[k+1] <= res_nxt;
      end
    end
  end

  assign root = res_r[N][qf_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/qf_div.sv =====
// ----------------------------------------------------------------------------
// qf_div
// Pipelined restoring divider for the length ratio, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qf_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qf_pkg::ROOT_W-1:0]   num,
  input  logic [qf_pkg::ROOT_W-1:0]   den,
  output logic [qf_pkg::QUOT_W-1:0]   quot
);

  localparam int RW = qf_pkg::ROOT_W;
  localparam int QW = qf_pkg::QUOT_W;
  localparam int NW = RW + qf_pkg::NUM_SH;

  logic [RW-1:0] r_r [1:QW];
  logic [QW-1:0] n_r [1:QW];
  logic [RW-1:0] d_r [1:QW];
  logic [QW-1:0] q_r [1:QW];
  logic [RW-1:0] r_s [0:QW-1];
  logic [QW-1:0] n_s [0:QW-1];
  logic [RW-1:0] d_s [0:QW-1];
  logic [QW-1:0] q_s [0:QW-1];
  logic [NW-1:0] nfull;

  assign nfull  = {num, {qf_pkg::NUM_SH{1'b0}}};
  assign r_s[0] = RW'(nfull >> QW);
  assign n_s[0] = nfull[QW-1:0];
  assign d_s[0] = den;
  assign q_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] r_nxt;

    if (k > 0) begin : g_link
      assign r_s[k] = r_r[k];
      assign n_s[k] = n_r[k];
      assign d_s[k] = d_r[k];
      assign q_s[k] = q_r[k];
    end

    always_comb begin
      trial = {r_s[k], n_s[k][QW-1]};
      ge    = (trial >= {1'b0, d_s[k]});
      r_nxt = ge ? RW'(trial - {1'b0, d_s[k]}) : trial[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1] <= r_nxt;
        n_r[k+1] <= n_s[k] << 1;
        d_r[k+1] <= d_s[k];
        q_r[k+1] <= {q_s[k][QW-2:0], ge};
      end
    end
  end

  assign quot = q_r[QW];

endmodule

`default_nettype wire

// ===== rtl/core/qf_front.sv =====
// ----------------------------------------------------------------------------
// qf_front
// Seven-stage front end: squaring, scaling, rotation, offset, and the
// normalized sums of squares for both lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module qf_front #(
  parameter int CW = 24,
  parameter int F  = 18
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [CW-1:0]          x,
  input  logic signed [CW-1:0]          y,
  input  logic signed [CW-1:0]          z,
  input  logic signed [CW-1:0]          w,
  input  logic [qf_pkg::DERIV_W-1:0]    deriv,
  input  logic [CW-1:0]                 radius,
  input  qf_pkg::qf_cfg_t               cfg,
  output logic [qf_pkg::SQ_SUM_W-1:0]   sum_p,
  output logic [qf_pkg::SQ_SUM_W-1:0]   sum_h,
  output logic [4*CW-1:0]               coords,
  output logic [qf_pkg::DERIV_W-1:0]    de1,
  output logic                          zero
);

  localparam int WM   = CW + 8;
  localparam int WS   = CW + 9;
  localparam int NW   = qf_pkg::NORM_W;
  localparam int MAXS = (WM + 1 > NW) ? WM + 1 - NW : 0;
  localparam int SHW  = $clog2(MAXS + 2);
  localparam int OW   = ((WS > F + 6) ? WS : F + 6) + 2;
  localparam int DW   = qf_pkg::DERIV_W;

  function automatic logic [WM-1:0] sq_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [2*CW-1:0] pr;
    logic [2*CW-1:0] ps;
    pr = (2*CW)'(a) * (2*CW)'(b);
    ps = pr >> F;
    return (ps[2*CW-1:WM] != '0) ? {WM{1'b1}} : ps[WM-1:0];
  endfunction

  function automatic logic [WM-1:0] magn(input logic [WS-1:0] v);
    logic [WS-1:0] n;
    n = -v;
    return v[WS-1] ? n[WM-1:0] : v[WM-1:0];
  endfunction

  function automatic logic [WS-1:0] mul_sat(input logic [15:0] c, input logic [WS-1:0] v,
                                           input int sh);
    logic [15:0]    mc;
    logic [WM-1:0]  mv;
    logic [WM+15:0] pr;
    logic [WM+15:0] ps;
    logic [WM-1:0]  r;
    mc = c[15] ? 16'(-c) : c;
    mv = magn(v);
    pr = (WM+16)'(mc) * (WM+16)'(mv);
    ps = pr >> sh;
    r  = (ps[WM+15:WM] != '0) ? {WM{1'b1}} : ps[WM-1:0];
    return (c[15] ^ v[WS-1]) ? -{1'b0, r} : {1'b0, r};
  endfunction

  // stage 1: products
  logic [CW-1:0]           ax, ay, az;
  logic [DW+CW-1:0]        pd, pds;
  logic [DW-1:0]           de1_c;
  logic [WM-1:0]           mxy, mxz;
  logic [WM-1:0]           s1_xx_r, s1_yy_r, s1_zz_r;
  logic [WS-1:0]           s1_xy_r, s1_xz_r;
  logic signed [CW-1:0]    s1_w_r;
  logic [DW-1:0]           de_r [1:7];
  logic                    zf_r [2:7];

  always_comb begin
    ax    = x[CW-1] ? CW'(-x) : x;
    ay    = y[CW-1] ? CW'(-y) : y;
    az    = z[CW-1] ? CW'(-z) : z;
    mxy   = sq_sat(ax, ay);
    mxz   = sq_sat(ax, az);
    pd    = (DW+CW)'(deriv) * (DW+CW)'(radius);
    pds   = pd >> (F - 1);
    de1_c = (pds[DW+CW-1:DW] != '0) ? {DW{1'b1}} : pds[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xx_r <= sq_sat(ax, ax);
      s1_yy_r <= sq_sat(ay, ay);
      s1_zz_r <= sq_sat(az, az);
      s1_xy_r <= (x[CW-1] ^ y[CW-1]) ? -{1'b0, mxy} : {1'b0, mxy};
      s1_xz_r <= (x[CW-1] ^ z[CW-1]) ? -{1'b0, mxz} : {1'b0, mxz};
      s1_w_r  <= w;
      de_r[1] <= de1_c;
    end
  end

  // stage 2: first component and zero test
  logic signed [WM+1:0] d0, lim;
  logic [WS-1:0]        p0_c, p3_c;
  logic [WS-1:0]        s2_p_r [4];

  always_comb begin
    lim = $signed({2'b00, {WM{1'b1}}});
    d0  = $signed({2'b00, s1_xx_r}) - $signed({2'b00, s1_yy_r}) - $signed({2'b00, s1_zz_r});
    if (d0 > lim) begin
      p0_c = {1'b0, {WM{1'b1}}};
    end else if (d0 < -lim) begin
      p0_c = -{1'b0, {WM{1'b1}}};
    end else begin
      p0_c = d0[WS-1:0];
    end
    p3_c = {{(WS-CW){s1_w_r[CW-1]}}, s1_w_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r[0] <= p0_c;
      s2_p_r[1] <= s1_xy_r;
      s2_p_r[2] <= s1_xz_r;
      s2_p_r[3] <= p3_c;
      zf_r[2]   <= (d0 == '0) && (s1_xy_r == '0) && (s1_xz_r == '0) && (s1_w_r == '0);
    end
  end

  // stage 3: per-component multipliers
  logic [WS-1:0] s3_t_r  [4];
  logic [WM-1:0] s3_pm_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s3_t_r[i]  <= mul_sat(cfg.scale[16*i +: 16], s2_p_r[i], qf_pkg::SCALE_SH);
        s3_pm_r[i] <= magn(s2_p_r[i]);
      end
    end
  end

  // stage 4: shared normalizing shift, rotation products
  logic [WM:0]           hm_c [4];
  logic [WM:0]           orv;
  logic [SHW-1:0]        s_c;
  logic [WM:0]           s4_hm_r [4];
  logic [WM:0]           s4_pm_r [4];
  logic [SHW-1:0]        s4_s_r;
  logic signed [WS-1:0]  s4_rp_r [3][3];
  logic signed [WS-1:0]  s4_t_r  [4];

  always_comb begin
    hm_c[0] = {magn(s3_t_r[0]), 1'b0};
    hm_c[1] = {1'b0, magn(s3_t_r[1])};
    hm_c[2] = {1'b0, magn(s3_t_r[2])};
    hm_c[3] = {magn(s3_t_r[3]), 1'b0};
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      orv = orv | hm_c[i] | {1'b0, s3_pm_r[i]};
    end
    s_c = '0;
    for (int k = 0; k < MAXS; k++) begin
      if ((orv >> (NW + k)) != '0) begin
        s_c = SHW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s4_hm_r[i] <= hm_c[i];
        s4_pm_r[i] <= {1'b0, s3_pm_r[i]};
        s4_t_r[i]  <= s3_t_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s4_rp_r[i][j] <= mul_sat(cfg.row[i][16*j +: 16], s3_t_r[j], qf_pkg::ROT_SH);
        end
      end
      s4_s_r <= s_c;
    end
  end

  // stage 5: shifted magnitudes, rotated and offset point
  logic [NW-1:0]         s5_a_r [8];
  logic [4*CW-1:0]       s5_c_r;
  logic [4*CW-1:0]       c_c;
  logic [WM:0]           shv [8];
  logic signed [WS+1:0]  acc, wlim;
  logic signed [WS-1:0]  v_c [4];
  logic signed [OW-1:0]  ve, oe, sm, cmax, cmin;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shv[i]     = s4_pm_r[i] >> s4_s_r;
      shv[i + 4] = s4_hm_r[i] >> s4_s_r;
    end
    wlim = $signed({3'b000, {WM{1'b1}}});
    for (int i = 0; i < 4; i++) begin
      v_c[i] = s4_t_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      acc = s4_rp_r[i][0];
      acc = acc + s4_rp_r[i][1] + s4_rp_r[i][2];
      if (cfg.rotate) begin
        if (acc > wlim) begin
          v_c[i] = $signed({1'b0, {WM{1'b1}}});
        end else if (acc < -wlim) begin
          v_c[i] = -$signed({1'b0, {WM{1'b1}}});
        end else begin
          v_c[i] = acc[WS-1:0];
        end
      end
    end
    cmax = $signed(OW'({1'b0, {(CW-1){1'b1}}}));
    cmin = -cmax - 1;
    c_c  = '0;
    for (int i = 0; i < 4; i++) begin
      ve = v_c[i];
      oe = $signed(cfg.offset[16*i +: 16]);
      oe = oe <<< (F - qf_pkg::OFF_FRAC);
      sm = ve + oe;
      if (sm > cmax) begin
        c_c[CW*i +: CW] = cmax[CW-1:0];
      end else if (sm < cmin) begin
        c_c[CW*i +: CW] = cmin[CW-1:0];
      end else begin
        c_c[CW*i +: CW] = sm[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        s5_a_r[i] <= NW'(shv[i]);
      end
      s5_c_r <= c_c;
    end
  end

  // stage 6: squares
  logic [qf_pkg::SQ_W-1:0] s6_sq_r [8];
  logic [4*CW-1:0]         s6_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        s6_sq_r[i] <= qf_pkg::SQ_W'(s5_a_r[i]) * qf_pkg::SQ_W'(s5_a_r[i]);
      end
      s6_c_r <= s5_c_r;
    end
  end

  // stage 7: sums of squares
  logic [qf_pkg::SQ_SUM_W-1:0] s7_sp_r, s7_sh_r;
  logic [4*CW-1:0]             s7_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sp_r <= qf_pkg::SQ_SUM_W'(s6_sq_r[0]) + qf_pkg::SQ_SUM_W'(s6_sq_r[1])
               + qf_pkg::SQ_SUM_W'(s6_sq_r[2]) + qf_pkg::SQ_SUM_W'(s6_sq_r[3]);
      s7_sh_r <= qf_pkg::SQ_SUM_W'(s6_sq_r[4]) + qf_pkg::SQ_SUM_W'(s6_sq_r[5])
               + qf_pkg::SQ_SUM_W'(s6_sq_r[6]) + qf_pkg::SQ_SUM_W'(s6_sq_r[7]);
      s7_c_r  <= s6_c_r;
    end
  end

  // side band
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 2; k <= 7; k++) begin
        de_r[k] <= de_r[k-1];
      end
      for (int k = 3; k <= 7; k++) begin
        zf_r[k] <= zf_r[k-1];
      end
    end
  end

  assign sum_p  = s7_sp_r;
  assign sum_h  = s7_sh_r;
  assign coords = s7_c_r;
  assign de1    = de_r[7];
  assign zero   = zf_r[7];

endmodule

`default_nettype wire

// ===== rtl/core/quaternion3d_fractal_iteration.sv =====
// ----------------------------------------------------------------------------
// quaternion3d_fractal_iteration
// One point a clock through a 67-stage pipeline: 7 front stages (products,
// scaling, rotation, normalized sums), 31 square-root stages, 26 divider
// stages for the length ratio and 3 stages for the derivative blend. The
// rate is one word per cycle while the output side takes words. A two-entry
// output buffer lets the pipeline keep moving while one finished word waits;
// when it holds two the whole pipeline holds and in_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module quaternion3d_fractal_iteration #(
  parameter int FRAC_BITS   = 18,
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_x,
  input  logic signed [COORD_WIDTH-1:0]     in_y,
  input  logic signed [COORD_WIDTH-1:0]     in_z,
  input  logic signed [COORD_WIDTH-1:0]     in_w,
  input  logic [qf_pkg::DERIV_W-1:0]        in_deriv,
  input  logic [COORD_WIDTH-1:0]            in_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_WIDTH-1:0]     out_x,
  output logic signed [COORD_WIDTH-1:0]     out_y,
  output logic signed [COORD_WIDTH-1:0]     out_z,
  output logic signed [COORD_WIDTH-1:0]     out_w,
  output logic [qf_pkg::DERIV_W-1:0]        out_deriv,
  output logic                              out_zero_length,
  input  logic                              cfg_we,
  input  logic [qf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = qf_pkg::DERIV_W;
  localparam int QW   = qf_pkg::QUOT_W;
  localparam int RS   = qf_pkg::ROOT_STEPS;
  localparam int FLAT = 7;
  localparam int DL   = RS + QW;
  localparam int L    = FLAT + DL + 3;
  localparam int SDW  = 4 * CW + DW + 1;

  // configuration
  qf_pkg::qf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale  <= qf_pkg::SCALE_RST;
      cfg_r.offset <= '0;
      cfg_r.row[0] <= qf_pkg::ROW0_RST;
      cfg_r.row[1] <= qf_pkg::ROW1_RST;
      cfg_r.row[2] <= qf_pkg::ROW2_RST;
      cfg_r.blend  <= qf_pkg::BLEND_RST;
      cfg_r.rotate <= 1'b0;
    end else if (cfg_we) begin
      case (qf_pkg::qf_cfg_idx_t'(cfg_index))
        qf_pkg::CFG_SCALE:     cfg_r.scale  <= cfg_data;
        qf_pkg::CFG_OFFSET:    cfg_r.offset <= cfg_data;
        qf_pkg::CFG_ROW_ONE:   cfg_r.row[0] <= cfg_data[47:0];
        qf_pkg::CFG_ROW_TWO:   cfg_r.row[1] <= cfg_data[47:0];
        qf_pkg::CFG_ROW_THREE: cfg_r.row[2] <= cfg_data[47:0];
        qf_pkg::CFG_BLEND:     cfg_r.blend  <= cfg_data[15:0];
        qf_pkg::CFG_ROTATE:    cfg_r.rotate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // flow control
  logic [1:0]   cnt_r;
  logic         adv;
  logic [L-1:0] vld_r;
  logic         push, pop;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign push     = adv && vld_r[L-1];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  // front end
  logic [qf_pkg::SQ_SUM_W-1:0] sum_p, sum_h;
  logic [4*CW-1:0]             f_coords;
  logic [DW-1:0]               f_de1;
  logic                        f_zero;

  qf_front #(.CW(CW), .F(FRAC_BITS)) u_front (
    .clk    (clk),
    .en     (adv),
    .x      (in_x),
    .y      (in_y),
    .z      (in_z),
    .w      (in_w),
    .deriv  (in_deriv),
    .radius (in_radius),
    .cfg    (cfg_r),
    .sum_p  (sum_p),
    .sum_h  (sum_h),
    .coords (f_coords),
    .de1    (f_de1),
    .zero   (f_zero)
  );

  // lengths and ratio
  logic [qf_pkg::ROOT_W-1:0] len_p, len_h;
  logic [QW-1:0]             quot;

  qf_isqrt u_root_p (.clk(clk), .en(adv), .rad_in(sum_p), .root(len_p));
  qf_isqrt u_root_h (.clk(clk), .en(adv), .rad_in(sum_h), .root(len_h));
  qf_div   u_div    (.clk(clk), .en(adv), .num(len_h), .den(len_p), .quot(quot));

  // side band over root and divider
  logic [SDW-1:0] sd_r   [DL];
  logic           unit_r [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= {f_coords, f_de1, f_zero};
      for (int k = 1; k < DL; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      unit_r[0] <= sd_r[RS-1][0] || (len_p == '0);
      for (int k = 1; k < QW; k++) begin
        unit_r[k] <= unit_r[k-1];
      end
    end
  end

  // derivative tail
  logic [QW-1:0]         avg;
  logic [DW+QW-1:0]      pt;
  logic [DW+QW-21:0]     t1_tgt_r;
  logic [SDW-1:0]        t1_sd_r, t2_sd_r, t3_sd_r;
  logic signed [39:0]    diff;
  logic signed [15:0]    blend_s;
  logic signed [55:0]    t2_prod_r;
  logic signed [55:0]    bsh;
  logic signed [56:0]    dsum;
  logic [DW-1:0]         de_new;
  logic [DW-1:0]         t3_de_r;

  always_comb begin
    avg     = unit_r[QW-1] ? QW'(1) << qf_pkg::RATIO_FRAC : quot;
    pt      = (DW+QW)'(sd_r[DL-1][DW:1]) * (DW+QW)'(avg);
    blend_s = $signed(cfg_r.blend);
    diff    = $signed({2'b00, t1_tgt_r}) - $signed({8'b0, t1_sd_r[DW:1]});
    bsh     = t2_prod_r >>> qf_pkg::BLEND_SH;
    dsum    = bsh;
    dsum    = dsum + $signed({25'b0, t2_sd_r[DW:1]});
    if (dsum < 0) begin
      de_new = '0;
    end else if (dsum[56:DW] != '0) begin
      de_new = {DW{1'b1}};
    end else begin
      de_new = dsum[DW-1:0];
    end
  end

  // target stays below 2^38, under its 2^40 cap
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_tgt_r  <= pt[DW+QW-1:qf_pkg::RATIO_FRAC];
      t1_sd_r   <= sd_r[DL-1];
      t2_prod_r <= diff * blend_s;
      t2_sd_r   <= t1_sd_r;
      t3_de_r   <= de_new;
      t3_sd_r   <= t2_sd_r;
    end
  end

  // output buffer
  localparam int RW = 4 * CW + DW + 1;
  logic [RW-1:0] res_c, q0_r, q1_r;
  logic [RW-1:0] q0_nxt, q1_nxt;
  logic [1:0]    slot;

  assign res_c = {t3_sd_r[SDW-1:DW+1], t3_de_r, t3_sd_r[0]};
  assign slot  = cnt_r - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_comb begin
    q0_nxt = pop ? q1_r : q0_r;
    q1_nxt = q1_r;
    if (push) begin
      if (slot == 2'd0) begin
        q0_nxt = res_c;
      end else begin
        q1_nxt = res_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_x           = q0_r[RW-1-3*CW -: CW];
  assign out_y           = q0_r[RW-1-2*CW -: CW];
  assign out_z           = q0_r[RW-1-CW -: CW];
  assign out_w           = q0_r[RW-1 -: CW];
  assign out_deriv       = q0_r[DW:1];
  assign out_zero_length = q0_r[0];

  `QF_ASSERT(a_cnt_range, cnt_r != 2'd3, "output buffer count out of range")
  `QF_ASSERT_NEXT(a_hold, !adv, $stable(vld_r) && $stable(t3_de_r), "stalled pipeline moved")
  `QF_ASSERT(a_fill, $fell(in_ready) |-> ($past(out_valid) && !$past(out_ready)), "early stall")

endmodule

`default_nettype wire

// ===== dv/quaternion3d_fractal_iteration_test.sv =====
// ----------------------------------------------------------------------------
// quaternion3d_fractal_iteration_test
// Drives points through the fractal iteration core under random flow control
// and checks every output word against a fixed-point model of one iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion3d_fractal_iteration_test;

  localparam int FB = 18;
  localparam int CW = 24;
  localparam longint WMAX = (64'sd1 <<< (CW + 8)) - 1;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int LAT = 67;

  typedef struct {
    logic signed [CW-1:0] x, y, z, w;
    logic [31:0]          deriv;
    logic                 zero;
  } point_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [CW-1:0] in_x = 0, in_y = 0, in_z = 0, in_w = 0;
  logic [31:0] in_deriv = 0;
  logic [CW-1:0] in_radius = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [CW-1:0] out_x, out_y, out_z, out_w;
  logic [31:0] out_deriv;
  logic out_zero_length;
  logic cfg_we = 0;
  logic [qf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [63:0] m_scale, m_offset;
  logic [47:0] m_row [3];
  logic [15:0] m_blend;
  logic m_rotate;

  point_t expected_points[$];
  int errors = 0;
  int words_seen = 0;
  int hold_cycles = 0;
  bit rand_stall = 0;

  quaternion3d_fractal_iteration u_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // |a|*|b| >> sh, saturated to lim; products fit 128 bits
  function automatic longint umul_sat(logic [63:0] a, logic [63:0] b, int sh,
                                      logic [63:0] lim);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p > {64'd0, lim}) ? lim : p[63:0];
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint smul(longint a, longint b, int sh);
    longint m;
    m = umul_sat(abs64(a), abs64(b), sh, WMAX);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sfield(logic [63:0] r, int i);
    logic signed [15:0] f;
    f = r[16*i +: 16];
    return f;
  endfunction

  function automatic point_t iterate(longint x, longint y, longint z, longint w,
                                     logic [31:0] de, logic [CW-1:0] rad);
    point_t o;
    longint p[4], t[4], v[4], acc, de2, d;
    logic [63:0] pm[4], hm[4], mx, sp, sh, lp, lh, avg, tgt, de1;
    int s;
    de1 = umul_sat(64'(de), 64'(rad), FB - 1, 64'hFFFF_FFFF);
    p[0] = clamp(smul(x, x, FB) - smul(y, y, FB) - smul(z, z, FB), -WMAX, WMAX);
    p[1] = smul(x, y, FB);
    p[2] = smul(x, z, FB);
    p[3] = w;
    o.zero = p[0] == 0 && p[1] == 0 && p[2] == 0 && p[3] == 0;
    for (int i = 0; i < 4; i++) t[i] = smul(sfield(m_scale, i), p[i], qf_pkg::SCALE_SH);
    for (int i = 0; i < 4; i++) pm[i] = abs64(p[i]);
    hm[0] = 2 * abs64(t[0]);
    hm[1] = abs64(t[1]);
    hm[2] = abs64(t[2]);
    hm[3] = 2 * abs64(t[3]);
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      if (pm[i] > mx) mx = pm[i];
      if (hm[i] > mx) mx = hm[i];
    end
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    avg = 64'd1 << qf_pkg::RATIO_FRAC;
    if (!o.zero) begin
      sp = 0;
      sh = 0;
      for (int i = 0; i < 4; i++) begin
        sp += (pm[i] >> s) * (pm[i] >> s);
        sh += (hm[i] >> s) * (hm[i] >> s);
      end
      lp = root_floor(sp);
      lh = root_floor(sh);
      if (lp != 0) avg = (lh << qf_pkg::NUM_SH) / lp;
    end
    tgt = umul_sat(de1, avg, qf_pkg::RATIO_FRAC, 64'd1 << 40);
    d = (longint'(tgt) - longint'(de1)) * sfield({48'd0, m_blend}, 0);
    de2 = longint'(de1) + (d >>> qf_pkg::BLEND_SH);
    de2 = clamp(de2, 0, 64'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) v[i] = t[i];
    if (m_rotate) begin
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += smul(sfield(64'(m_row[i]), j), t[j], qf_pkg::ROT_SH);
        v[i] = clamp(acc, -WMAX, WMAX);
      end
    end
    for (int i = 0; i < 4; i++)
      v[i] = clamp(v[i] + sfield(m_offset, i) * (64'sd1 <<< (FB - qf_pkg::OFF_FRAC)),
                   CMIN, CMAX);
    o.x = CW'(v[0]);
    o.y = CW'(v[1]);
    o.z = CW'(v[2]);
    o.w = CW'(v[3]);
    o.deriv = 32'(de2);
    return o;
  endfunction

  task automatic write_reg(qf_pkg::qf_cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      qf_pkg::CFG_SCALE:     m_scale = val;
      qf_pkg::CFG_OFFSET:    m_offset = val;
      qf_pkg::CFG_ROW_ONE:   m_row[0] = val[47:0];
      qf_pkg::CFG_ROW_TWO:   m_row[1] = val[47:0];
      qf_pkg::CFG_ROW_THREE: m_row[2] = val[47:0];
      qf_pkg::CFG_BLEND:     m_blend = val[15:0];
      qf_pkg::CFG_ROTATE:    m_rotate = val[0];
      default: ;
    endcase
  endtask

  // valid stays high after acceptance; the caller drops it when it idles
  task automatic send_point(logic [CW-1:0] x, y, z, w, logic [31:0] de,
                            logic [CW-1:0] rad);
    in_valid <= 1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    in_w <= w;
    in_deriv <= de;
    in_radius <= rad;
    expected_points.push_back(iterate($signed(x), $signed(y), $signed(z), $signed(w),
                                      de, rad));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CW'($urandom);
      1: return CW'(CMAX);
      2: return CW'(CMIN);
      default: return CW'($signed($urandom_range(0, 2 * (1 << FB))) - (1 << FB));
    endcase
  endfunction

  // bursts of random length with random gaps
  task automatic random_points(int n, bit narrow);
    int burst;
    int gap;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      burst--;
      if (narrow)
        send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, 1 << 20), CW'($urandom_range(0, 1 << 19)));
      else
        send_point(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                   $urandom, CW'($urandom));
    end
  endtask

  task automatic test_directed();
    logic [CW-1:0] cmx, cmn, one;
    cmx = CW'(CMAX);
    cmn = CW'(CMIN);
    one = CW'(1 << FB);
    send_point(0, 0, 0, 0, 32'h0001_0000, one);
    send_point(0, 0, 0, 0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_point(cmx, cmx, cmx, cmx, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_point(cmn, cmn, cmn, cmn, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_point(cmx, cmn, 0, cmn, 0, 0);
    send_point(one, 0, 0, 0, 32'h0001_0000, one);
    send_point(0, one, 0, 0, 32'h0001_0000, one);
    send_point(0, 0, one, 1, 32'h0001_0000, one);
    send_point(1, 1, 1, 0, 32'h0000_0001, 1);
    send_point(24'h80_0000, 1, 0, 24'hFF_FFFF, 32'h8000_0000, 24'h80_0000);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [63:0] sc[4];
    sc[0] = 64'h7FFF_8000_7FFF_8000;
    sc[1] = 64'h8000_7FFF_0000_FFFF;
    sc[2] = 64'h0000_0000_0000_0000;
    sc[3] = {$urandom, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(qf_pkg::CFG_SCALE, sc[ph]);
      write_reg(qf_pkg::CFG_OFFSET,
                ph == 0 ? 64'h7FFF_8000_7FFF_8000 : {$urandom, $urandom});
      write_reg(qf_pkg::CFG_ROW_ONE, ph == 1 ? 48'h8000_8000_8000 : {$urandom, $urandom});
      write_reg(qf_pkg::CFG_ROW_TWO, ph == 1 ? 48'h7FFF_7FFF_7FFF : {$urandom, $urandom});
      write_reg(qf_pkg::CFG_ROW_THREE, {$urandom, $urandom});
      write_reg(qf_pkg::CFG_BLEND, ph == 0 ? 16'h7FFF : (ph == 1 ? 16'h8000 : $urandom));
      write_reg(qf_pkg::CFG_ROTATE, ph != 2);
      random_points(150, ph[0]);
      drain();
    end
    write_reg(qf_pkg::CFG_SCALE, qf_pkg::SCALE_RST);
    write_reg(qf_pkg::CFG_OFFSET, 0);
    write_reg(qf_pkg::CFG_ROW_ONE, qf_pkg::ROW0_RST);
    write_reg(qf_pkg::CFG_ROW_TWO, qf_pkg::ROW1_RST);
    write_reg(qf_pkg::CFG_ROW_THREE, qf_pkg::ROW2_RST);
    write_reg(qf_pkg::CFG_BLEND, qf_pkg::BLEND_RST);
    write_reg(qf_pkg::CFG_ROTATE, 1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    random_points(200, 1);
    drain();
  endtask

  task automatic test_random_stream();
    rand_stall = 1;
    random_points(400, 1);
    random_points(400, 0);
    drain();
  endtask

  // receiver: long hold when asked, its own stall pattern when random stalls are on, otherwise always ready
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 0;
        hold_cycles--;
      end else if (rand_stall) begin
        phase = (phase + 1) % 13;
        out_ready <= (phase < 8) ? ($urandom_range(0, 3) != 0) : 1'b0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word at %0t", $realtime);
      end else begin
        e = expected_points.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_w !== e.w ||
            out_deriv !== e.deriv || out_zero_length !== e.zero) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h %h %h %b got %h %h %h %h %h %b",
                     e.x, e.y, e.z, e.w, e.deriv, e.zero,
                     out_x, out_y, out_z, out_w, out_deriv, out_zero_length);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("quaternion3d_fractal_iteration_test: errors");
    $finish;
  end

  initial begin
    m_scale = qf_pkg::SCALE_RST;
    m_offset = 0;
    m_row[0] = qf_pkg::ROW0_RST;
    m_row[1] = qf_pkg::ROW1_RST;
    m_row[2] = qf_pkg::ROW2_RST;
    m_blend = qf_pkg::BLEND_RST;
    m_rotate = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_stream();
    if (expected_points.size() != 0) errors++;
    $display("covered %0d words: corners, zero length, register extremes, rotation on/off,",
             words_seen);
    $display("long output hold and random flow control; %0d errors", errors);
    if (errors == 0)
      $display("quaternion3d_fractal_iteration_test: clean");
    else
      $display("quaternion3d_fractal_iteration_test: errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/qf_pkg.sv
rtl/core/qf_isqrt.sv
rtl/core/qf_div.sv
rtl/core/qf_front.sv
rtl/core/quaternion3d_fractal_iteration.sv
dv/quaternion3d_fractal_iteration_test.sv
